### hdl/rotation_matrix_to_quaternion_top_assert.svh
// Assertion macros for the quaternion converter
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq assertion failed");
`define RMQ_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rmq forbidden condition");
`else
`define RMQ_ASSERT_IMPL(lbl, ante, cons)
`define RMQ_ASSERT_NEVER(lbl, expr)
`endif
`endif

### hdl/rmq_pkg.sv
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;

  typedef enum logic [1:0] {
    BIG_W = 2'd0,
    BIG_X = 2'd1,
    BIG_Y = 2'd2,
    BIG_Z = 2'd3
  } big_t;

  typedef struct packed {
    logic       valid;
    logic       inval;
    logic       tone;
    logic       neg;
    big_t       big;
    logic [2:0] dneg;
  } ctl_t;

endpackage

### hdl/rmq_sqrt_cell.sv
module rmq_sqrt_cell #(
  parameter int NW = 34,
  parameter int RW = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  rmq_pkg::ctl_t       ctl_i,
  input  logic [NW-1:0]       rad_i,
  input  logic [RW:0]         rem_i,
  input  logic [RW-1:0]       root_i,
  input  logic [2:0][16:0]    mag_i,
  output rmq_pkg::ctl_t       ctl_o,
  output logic [NW-1:0]       rad_o,
  output logic [RW:0]         rem_o,
  output logic [RW-1:0]       root_o,
  output logic [2:0][16:0]    mag_o
);
  import rmq_pkg::*;

  logic [RW+2:0] sh;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  assign sh    = {rem_i, rad_i[NW-1:NW-2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = sh - trial;
  assign ge    = sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else begin
      ctl_o.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_o.inval <= ctl_i.inval;
    ctl_o.tone  <= ctl_i.tone;
    ctl_o.neg   <= ctl_i.neg;
    ctl_o.big   <= ctl_i.big;
    ctl_o.dneg  <= ctl_i.dneg;
    rad_o       <= {rad_i[NW-3:0], 2'b00};
    rem_o       <= ge ? diff[RW:0] : sh[RW:0];
    root_o      <= {root_i[RW-2:0], ge};
    mag_o       <= mag_i;
  end

endmodule

### hdl/rmq_div_cell.sv
module rmq_div_cell #(
  parameter int DW = 32,
  parameter int RW = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  rmq_pkg::ctl_t       ctl_i,
  input  logic [RW-1:0]       r_i,
  input  logic [2:0][DW-1:0]  num_i,
  input  logic [2:0][RW:0]    rem_i,
  input  logic [2:0][DW-1:0]  quo_i,
  output rmq_pkg::ctl_t       ctl_o,
  output logic [RW-1:0]       r_o,
  output logic [2:0][DW-1:0]  num_o,
  output logic [2:0][RW:0]    rem_o,
  output logic [2:0][DW-1:0]  quo_o
);
  import rmq_pkg::*;

  logic [RW+1:0]      dv;
  logic [2:0][RW+1:0] sh;
  logic [2:0][RW+1:0] df;
  logic [2:0]         ge;

  assign dv = {1'b0, r_i, 1'b0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {rem_i[i], num_i[i][DW-1]};
      df[i] = sh[i] - dv;
      ge[i] = sh[i] >= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else begin
      ctl_o.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_o.inval <= ctl_i.inval;
    ctl_o.tone  <= ctl_i.tone;
    ctl_o.neg   <= ctl_i.neg;
    ctl_o.big   <= ctl_i.big;
    ctl_o.dneg  <= ctl_i.dneg;
    r_o         <= r_i;
    for (int i = 0; i < 3; i++) begin
      num_o[i] <= {num_i[i][DW-2:0], 1'b0};
      rem_o[i] <= ge[i] ? df[i][RW:0] : sh[i][RW:0];
      quo_o[i] <= {quo_i[i][DW-2:0], ge[i]};
    end
  end

endmodule

### hdl/rotation_matrix_to_quaternion_top.sv
// Pipeline from start to done, at Q1.14: input register, one square
//   root cell per root bit (17), divider input register, one divider cell per quotient
//   bit (32), output register.
// Throughput: one matrix per cycle; busy is low except during reset; done is never held off.
// Reset (rst, synchronous) clears the valid bits of every cell; done is low after it.
`include "rotation_matrix_to_quaternion_top_assert.svh"
module rotation_matrix_to_quaternion_top #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic               done,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic               invalid
);
  import rmq_pkg::*;

  localparam int TU  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int TW  = TU + 1;
  localparam int NW  = ((TU + FRAC_BITS) % 2 == 0) ? (TU + FRAC_BITS) : (TU + FRAC_BITS + 1);
  localparam int RW  = NW / 2;
  localparam int SQ  = RW;
  localparam int DW  = (((FRAC_BITS + 17) > RW) ? (FRAC_BITS + 17) : RW) + 1;
  localparam int LAT = SQ + DW + 3;
  localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
  localparam logic [15:0] ONE_SAT = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

  logic accept;
  assign busy   = rst;
  assign accept = start & ~busy;

  // front end
  logic signed [TW-1:0] e00, e11, e22, t;
  logic signed [16:0]   s00, s01, s02, s10, s11, s12, s20, s21;
  logic signed [2:0][16:0] d;
  ctl_t                 ctl_next;

  always_comb begin
    e00 = TW'(m00);
    e11 = TW'(m11);
    e22 = TW'(m22);
    s00 = 17'(m00);
    s01 = 17'(m01);
    s02 = 17'(m02);
    s10 = 17'(m10);
    s11 = 17'(m11);
    s12 = 17'(m12);
    s20 = 17'(m20);
    s21 = 17'(m21);
    ctl_next.valid = accept;
    ctl_next.neg   = 1'b0;
    if (m22 < 0) begin
      if (m00 > m11) begin
        ctl_next.big = BIG_X;
        t = ONE_T + e00 - e11 - e22;
        ctl_next.neg = m12 < m21;
        d[0] = s12 - s21;
        d[1] = s01 + s10;
        d[2] = s20 + s02;
      end else begin
        ctl_next.big = BIG_Y;
        t = ONE_T - e00 + e11 - e22;
        ctl_next.neg = m20 < m02;
        d[0] = s20 - s02;
        d[1] = s01 + s10;
        d[2] = s12 + s21;
      end
    end else begin
      if (s00 < -s11) begin
        ctl_next.big = BIG_Z;
        t = ONE_T - e00 - e11 + e22;
        ctl_next.neg = m01 < m10;
        d[0] = s01 - s10;
        d[1] = s20 + s02;
        d[2] = s12 + s21;
      end else begin
        ctl_next.big = BIG_W;
        t = ONE_T + e00 + e11 + e22;
        d[0] = s12 - s21;
        d[1] = s20 - s02;
        d[2] = s01 - s10;
      end
    end
    ctl_next.inval = t <= 0;
    ctl_next.tone  = t == ONE_T;
    for (int i = 0; i < 3; i++) begin
      ctl_next.dneg[i] = d[i][16];
    end
  end

  ctl_t                 sq_ctl  [SQ+1];
  logic [NW-1:0]        sq_rad  [SQ+1];
  logic [RW:0]          sq_rem  [SQ+1];
  logic [RW-1:0]        sq_root [SQ+1];
  logic [2:0][16:0]     sq_mag  [SQ+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl[0].valid <= 1'b0;
    end else begin
      sq_ctl[0].valid <= ctl_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_ctl[0].inval <= ctl_next.inval;
    sq_ctl[0].tone  <= ctl_next.tone;
    sq_ctl[0].neg   <= ctl_next.neg;
    sq_ctl[0].big   <= ctl_next.big;
    sq_ctl[0].dneg  <= ctl_next.dneg;
    sq_rad[0]       <= NW'(t[TU-1:0]) << FRAC_BITS;
    sq_rem[0]       <= '0;
    sq_root[0]      <= '0;
    for (int i = 0; i < 3; i++) begin
      sq_mag[0][i] <= d[i][16] ? 17'(-d[i]) : 17'(d[i]);
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    rmq_sqrt_cell #(.NW(NW), .RW(RW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl_i  (sq_ctl[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .mag_i  (sq_mag[k]),
      .ctl_o  (sq_ctl[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .mag_o  (sq_mag[k+1])
    );
  end

  ctl_t                dv_ctl [DW+1];
  logic [RW-1:0]       dv_r   [DW+1];
  logic [2:0][DW-1:0]  dv_num [DW+1];
  logic [2:0][RW:0]    dv_rem [DW+1];
  logic [2:0][DW-1:0]  dv_quo [DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0].valid <= 1'b0;
    end else begin
      dv_ctl[0].valid <= sq_ctl[SQ].valid;
    end
  end

  always_ff @(posedge clk) begin
    dv_ctl[0].inval <= sq_ctl[SQ].inval;
    dv_ctl[0].tone  <= sq_ctl[SQ].tone;
    dv_ctl[0].neg   <= sq_ctl[SQ].neg;
    dv_ctl[0].big   <= sq_ctl[SQ].big;
    dv_ctl[0].dneg  <= sq_ctl[SQ].dneg;
    dv_r[0]         <= sq_root[SQ];
    for (int i = 0; i < 3; i++) begin
      dv_num[0][i] <= (DW'(sq_mag[SQ][i]) << FRAC_BITS) + DW'(sq_root[SQ]);
      dv_rem[0][i] <= '0;
      dv_quo[0][i] <= '0;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    rmq_div_cell #(.DW(DW), .RW(RW)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl_i (dv_ctl[k]),
      .r_i   (dv_r[k]),
      .num_i (dv_num[k]),
      .rem_i (dv_rem[k]),
      .quo_i (dv_quo[k]),
      .ctl_o (dv_ctl[k+1]),
      .r_o   (dv_r[k+1]),
      .num_o (dv_num[k+1]),
      .rem_o (dv_rem[k+1]),
      .quo_o (dv_quo[k+1])
    );
  end

  function automatic logic [15:0] sat_mag(input logic [DW-1:0] q, input logic negate);
    logic [15:0] res;
    if (negate) begin
      res = (q > DW'(32768)) ? 16'h8000 : 16'(16'h0 - q[15:0]);
    end else begin
      res = (q > DW'(32767)) ? 16'h7fff : q[15:0];
    end
    return res;
  endfunction

  ctl_t         fc;
  logic [RW:0]  c1;
  logic [15:0]  cv;
  logic [2:0][15:0] lv;
  logic         allz;
  logic [15:0]  w_next, x_next, y_next, z_next;

  always_comb begin
    fc   = dv_ctl[DW];
    c1   = {1'b0, dv_r[DW]} + (RW+1)'(1);
    cv   = sat_mag(DW'(c1[RW:1]), fc.neg);
    allz = 1'b1;
    for (int i = 0; i < 3; i++) begin
      lv[i] = sat_mag(dv_quo[DW][i], fc.dneg[i] != fc.neg);
      if (dv_quo[DW][i] != '0) begin
        allz = 1'b0;
      end
    end
    if (fc.tone && allz) begin
      cv = ONE_SAT;
    end
    case (fc.big)
      BIG_W: begin
        w_next = cv;    x_next = lv[0]; y_next = lv[1]; z_next = lv[2];
      end
      BIG_X: begin
        w_next = lv[0]; x_next = cv;    y_next = lv[1]; z_next = lv[2];
      end
      BIG_Y: begin
        w_next = lv[0]; x_next = lv[1]; y_next = cv;    z_next = lv[2];
      end
      default: begin
        w_next = lv[0]; x_next = lv[1]; y_next = lv[2]; z_next = cv;
      end
    endcase
    if (fc.inval) begin
      w_next = '0;
      x_next = '0;
      y_next = '0;
      z_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fc.valid;
    end
  end

  always_ff @(posedge clk) begin
    quat_w  <= w_next;
    quat_x  <= x_next;
    quat_y  <= y_next;
    quat_z  <= z_next;
    invalid <= fc.inval;
  end

  `RMQ_ASSERT_IMPL(a_latency, $past(!rst, LAT), done == $past(accept, LAT))
  `RMQ_ASSERT_IMPL(a_inval_zero, done && invalid, {quat_w, quat_x, quat_y, quat_z} == '0)
  `RMQ_ASSERT_IMPL(a_w_nonneg, done && !invalid, !quat_w[15])
  `RMQ_ASSERT_NEVER(a_busy_run, busy && !rst)

endmodule
